@@ rtl/core/mte_pkg.sv @@
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants for the MIDI track event encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

  localparam int unsigned MaxBytes     = 7;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [1:0] OP_CHAN2 = 2'd0;
  localparam logic [1:0] OP_CHAN1 = 2'd1;
  localparam logic [1:0] OP_TEMPO = 2'd2;
  localparam logic [1:0] OP_EOT   = 2'd3;

  localparam logic [7:0] META_PREFIX = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] TEMPO_LEN   = 8'h03;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [27:0] delta_time;
    logic [3:0]  command;
    logic [3:0]  channel;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [23:0] tempo;
  } mte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } mte_out_t;

  // One encoded event: bytes in file order from index 0, count is 2..7
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
  } mte_plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mte_q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/midi_track_event_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_encoder_unit
// Encodes track events into Standard MIDI File bytes with running status.
// ----------------------------------------------------------------------------
// Path: push writes the plan queue; the plan then loads the output register.
// Throughput: one byte per cycle on the result port while pop is held high;
//   an event has 2 to 7 bytes, and the plan queue lets events enter meanwhile.
// Reset: asynchronous, clears running status, the plan queue and the output.
`default_nettype none

module midi_track_event_encoder_unit import mte_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push,
  output logic         full,
  input  wire mte_in_t in_i,
  output logic         empty,
  input  wire logic    pop,
  output mte_out_t     out_o
);

  logic          accept;
  logic          q_rd;
  mte_plan_t     wr_plan, rd_plan;
  mte_q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  mte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ev_i     (in_i),
    .plan_o   (wr_plan)
  );

  mte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_plan_i (wr_plan),
    .rd_i      (q_rd),
    .rd_plan_o (rd_plan),
    .status_o  (q_status)
  );

  mte_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_status.empty),
    .q_plan_i  (rd_plan),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .out_o     (out_o)
  );

  // idle output picks up a waiting plan at once
  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !q_status.empty |=> !empty)
    else $error("waiting plan not loaded");

  // an event never runs dry before its last byte
  a_no_gap_mid_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !out_o.last |=> !empty)
    else $error("output went empty inside an event");

  // an accepted word lands in the queue
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> !q_status.empty)
    else $error("accepted word missing from queue");

endmodule

`default_nettype wire

@@ rtl/core/mte_front.sv @@
// ----------------------------------------------------------------------------
// mte_front
// Classifies an event, tracks running status and builds its byte plan.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_front import mte_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire mte_in_t   ev_i,
  output mte_plan_t      plan_o
);

  logic [7:0] status_q, status_d;
  logic [7:0] status;
  logic       is_chan;
  logic       emit_status;
  logic [2:0] vlq_len;
  logic [3:0][7:0] vlq_bytes;

  assign is_chan     = (ev_i.opcode == OP_CHAN2) || (ev_i.opcode == OP_CHAN1);
  assign status      = {ev_i.command, ev_i.channel};
  assign emit_status = (status != status_q);

  always_comb begin
    if (ev_i.delta_time[27:21] != 7'd0) begin
      vlq_len = 3'd4;
    end else if (ev_i.delta_time[20:14] != 7'd0) begin
      vlq_len = 3'd3;
    end else if (ev_i.delta_time[13:7] != 7'd0) begin
      vlq_len = 3'd2;
    end else begin
      vlq_len = 3'd1;
    end
  end

  // group i carries bits 7i+6..7i, continuation set on all but group 0
  assign vlq_bytes[0] = {1'b0, ev_i.delta_time[6:0]};
  assign vlq_bytes[1] = {1'b1, ev_i.delta_time[13:7]};
  assign vlq_bytes[2] = {1'b1, ev_i.delta_time[20:14]};
  assign vlq_bytes[3] = {1'b1, ev_i.delta_time[27:21]};

  always_comb begin
    logic [2:0] j;
    plan_o = '0;
    j      = '0;
    case (ev_i.opcode)
      OP_CHAN2, OP_CHAN1: begin
        for (int k = 0; k < MaxBytes; k++) begin
          if (3'(k) < vlq_len) begin
            plan_o.bytes[k] = vlq_bytes[2'(vlq_len - 3'(k) - 3'd1)];
          end else begin
            j = 3'(k) - vlq_len;
            if (emit_status) begin
              if (j == 3'd0) plan_o.bytes[k] = status;
              else if (j == 3'd1) plan_o.bytes[k] = {1'b0, ev_i.data1};
              else if (j == 3'd2) plan_o.bytes[k] = {1'b0, ev_i.data2};
            end else begin
              if (j == 3'd0) plan_o.bytes[k] = {1'b0, ev_i.data1};
              else if (j == 3'd1) plan_o.bytes[k] = {1'b0, ev_i.data2};
            end
          end
        end
        plan_o.count = vlq_len + {2'b00, emit_status} + 3'd1
                     + {2'b00, (ev_i.opcode == OP_CHAN2)};
      end
      OP_TEMPO: begin
        plan_o.bytes[0] = 8'h00;
        plan_o.bytes[1] = META_PREFIX;
        plan_o.bytes[2] = META_TEMPO;
        plan_o.bytes[3] = TEMPO_LEN;
        plan_o.bytes[4] = ev_i.tempo[23:16];
        plan_o.bytes[5] = ev_i.tempo[15:8];
        plan_o.bytes[6] = ev_i.tempo[7:0];
        plan_o.count    = 3'd7;
      end
      default: begin
        plan_o.bytes[0] = 8'h00;
        plan_o.bytes[1] = META_PREFIX;
        plan_o.bytes[2] = META_EOT;
        plan_o.bytes[3] = 8'h00;
        plan_o.count    = 3'd4;
      end
    endcase
  end

  // meta events clear running status
  always_comb begin
    status_d = status_q;
    if (accept_i) begin
      status_d = is_chan ? status : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 8'h00;
    end else begin
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mte_queue.sv @@
// ----------------------------------------------------------------------------
// mte_queue
// Short queue of byte plans between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_queue import mte_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  wire mte_plan_t wr_plan_i,
  input  wire logic      rd_i,
  output mte_plan_t      rd_plan_o,
  output mte_q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mte_plan_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign rd_plan_o      = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mte_back.sv @@
// ----------------------------------------------------------------------------
// mte_back
// Serializes one byte plan into result words, one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

module mte_back import mte_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_empty_i,
  input  wire mte_plan_t q_plan_i,
  output logic           q_rd_o,
  output logic           empty,
  input  wire logic      pop,
  output mte_out_t       out_o
);

  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [2:0] rem_q, rem_d;
  logic       valid_q, valid_d;
  logic       take, fin;

  assign take   = valid_q && pop;
  assign fin    = take && (rem_q == 3'd1);
  assign q_rd_o = (!valid_q || fin) && !q_empty_i;

  assign empty          = !valid_q;
  assign out_o.out_byte = bytes_q[0];
  assign out_o.last     = (rem_q == 3'd1);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    if (q_rd_o) begin
      bytes_d = q_plan_i.bytes;
      rem_d   = q_plan_i.count;
      valid_d = 1'b1;
    end else if (take) begin
      bytes_d = {8'h00, bytes_q[MaxBytes-1:1]};
      rem_d   = rem_q - 3'd1;
      if (fin) valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

@@ verif/midi_track_event_encoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_encoder_unit_tb
// Drives track events into the encoder and checks every emitted file byte
// against a local byte predictor that keeps its own running status. Directed
// tests cover delta lengths, running status and meta events, then random
// traffic runs with random idle gaps on both the push and the pop side.
// ----------------------------------------------------------------------------

module midi_track_event_encoder_unit_tb;
  import mte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned InW        = $bits(mte_in_t);

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push   = 1'b0;
  logic     pop    = 1'b0;
  mte_in_t  in_i   = '0;
  logic     full;
  logic     empty;
  mte_out_t out_o;

  mte_out_t   expected_bytes [$];
  logic [7:0] status_shadow = 8'h00;
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         pop_stall = 0;
  bit         no_idle = 1'b0;

  midi_track_event_encoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  always #2 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Expected file bytes of one accepted event
  function automatic void encode_event(input mte_in_t ev);
    logic [7:0] seq [$];
    logic [7:0] status;
    logic [7:0] grp;
    int         vlq_len;
    mte_out_t   word;
    if (ev.opcode == OP_CHAN2 || ev.opcode == OP_CHAN1) begin
      vlq_len = 1;
      if (ev.delta_time[27:21] != 0) vlq_len = 4;
      else if (ev.delta_time[20:14] != 0) vlq_len = 3;
      else if (ev.delta_time[13:7] != 0) vlq_len = 2;
      for (int i = vlq_len - 1; i >= 0; i--) begin
        grp = {1'b0, 7'((ev.delta_time >> (7 * i)) & 28'h7F)};
        if (i != 0) grp[7] = 1'b1;
        seq.insert(seq.size(), grp);
      end
      status = {ev.command, ev.channel};
      if (status != status_shadow) begin
        seq.insert(seq.size(), status);
        status_shadow = status;
      end
      seq.insert(seq.size(), {1'b0, ev.data1});
      if (ev.opcode == OP_CHAN2) seq.insert(seq.size(), {1'b0, ev.data2});
    end else if (ev.opcode == OP_TEMPO) begin
      seq = '{8'h00, META_PREFIX, META_TEMPO, TEMPO_LEN,
              ev.tempo[23:16], ev.tempo[15:8], ev.tempo[7:0]};
      status_shadow = 8'h00;
    end else begin
      seq = '{8'h00, META_PREFIX, META_EOT, 8'h00};
      status_shadow = 8'h00;
    end
    foreach (seq[i]) begin
      word.out_byte = seq[i];
      word.last     = (i == seq.size() - 1);
      expected_bytes.insert(expected_bytes.size(), word);
    end
  endfunction

  // Channel event; tempo is unused and filled with noise
  function automatic mte_in_t chan_event(input logic [1:0] op, input logic [27:0] delta,
                                         input logic [3:0] cmd, input logic [3:0] ch,
                                         input logic [6:0] d1, input logic [6:0] d2);
    mte_in_t ev;
    ev.opcode     = op;
    ev.delta_time = delta;
    ev.command    = cmd;
    ev.channel    = ch;
    ev.data1      = d1;
    ev.data2      = d2;
    ev.tempo      = 24'($urandom);
    return ev;
  endfunction

  // Meta event; channel fields are unused and filled with noise
  function automatic mte_in_t meta_event(input logic [1:0] op, input logic [23:0] tmp);
    mte_in_t ev;
    ev            = mte_in_t'(InW'({$urandom, $urandom, $urandom}));
    ev.opcode     = op;
    ev.tempo      = tmp;
    return ev;
  endfunction

  task automatic send_event(input mte_in_t ev);
    int gap;
    push <= 1'b1;
    in_i <= ev;
    do @(posedge clk_i); while (full);
    encode_event(ev);
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Status 00 matches the reset value and must be left out
  task automatic test_reset_status();
    send_event(chan_event(OP_CHAN2, 28'd0, 4'h0, 4'h0, 7'h00, 7'h00));
    send_event(chan_event(OP_CHAN1, 28'd0, 4'h0, 4'h0, 7'h7F, 7'h55));
  endtask

  task automatic test_delta_lengths();
    logic [27:0] deltas [8];
    deltas = '{28'h0, 28'h7F, 28'h80, 28'h3FFF, 28'h4000, 28'h1FFFFF, 28'h200000,
               28'hFFFFFFF};
    foreach (deltas[i])
      send_event(chan_event(OP_CHAN2, deltas[i], 4'h9, 4'(i), 7'(i * 17), 7'h7F - 7'(i)));
  endtask

  task automatic test_running_status();
    send_event(chan_event(OP_CHAN2, 28'd5, 4'h8, 4'h3, 7'h40, 7'h00));
    send_event(chan_event(OP_CHAN2, 28'd1, 4'h8, 4'h3, 7'h41, 7'h7F));
    // low command nibble: status byte goes out with bit 7 clear
    send_event(chan_event(OP_CHAN1, 28'd200, 4'h3, 4'h5, 7'h12, 7'h00));
    send_event(chan_event(OP_CHAN2, 28'hFFFFFFF, 4'hF, 4'hF, 7'h7F, 7'h7F));
    send_event(chan_event(OP_CHAN1, 28'd0, 4'hF, 4'hF, 7'h00, 7'h7F));
  endtask

  // Meta events clear running status, so the next status goes out again
  task automatic test_meta_events();
    send_event(meta_event(OP_TEMPO, 24'h000000));
    send_event(chan_event(OP_CHAN2, 28'd3, 4'hF, 4'hF, 7'h01, 7'h02));
    send_event(meta_event(OP_TEMPO, 24'hFFFFFF));
    send_event(meta_event(OP_EOT, 24'h123456));
    send_event(chan_event(OP_CHAN1, 28'd0, 4'h0, 4'h0, 7'h33, 7'h00));
    send_event(meta_event(OP_TEMPO, 24'h07A120));
    send_event(meta_event(OP_EOT, 24'hABCDEF));
  endtask

  task automatic test_random_traffic(input int count);
    mte_in_t ev;
    int      r;
    for (int n = 0; n < count; n++) begin
      ev = mte_in_t'(InW'({$urandom, $urandom, $urandom}));
      r = $urandom_range(0, 99);
      if (r < 45) ev.opcode = OP_CHAN2;
      else if (r < 80) ev.opcode = OP_CHAN1;
      else if (r < 92) ev.opcode = OP_TEMPO;
      else ev.opcode = OP_EOT;
      case ($urandom_range(0, 4))
        0: ev.delta_time = 28'd0;
        1: ev.delta_time = 28'($urandom_range(0, 28'h7F));
        2: ev.delta_time = 28'($urandom_range(28'h80, 28'h3FFF));
        3: ev.delta_time = 28'($urandom_range(28'h4000, 28'h1FFFFF));
        default: ev.delta_time = 28'($urandom_range(28'h200000, 28'hFFFFFFF));
      endcase
      // lean on running status so omitted status bytes are common
      r = $urandom_range(0, 9);
      if (r < 4) {ev.command, ev.channel} = status_shadow;
      else if (r == 4) {ev.command, ev.channel} = 8'h00;
      send_event(ev);
    end
  endtask

  task automatic test_drain_pause();
    test_random_traffic(12);
    drain_results();
    test_random_traffic(12);
    drain_results();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(30);
    no_idle = 1'b0;
  endtask

  // Result side: pop with random stalls
  always @(posedge clk_i) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) pop_stall = idle_gap() + 1;
    end
  end

  // Compare each popped word with the oldest expected byte
  always @(posedge clk_i) begin
    mte_out_t exp_word;
    if (rst_ni && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected word: out_byte %02h last %0b", out_o.out_byte, out_o.last);
        mismatch_count++;
      end else begin
        exp_word = expected_bytes.pop_front();
        if (out_o.out_byte !== exp_word.out_byte) begin
          $error("out_byte mismatch: expected %02h, actual %02h",
                 exp_word.out_byte, out_o.out_byte);
          mismatch_count++;
        end
        if (out_o.last !== exp_word.last) begin
          $error("last mismatch: expected %0b, actual %0b", exp_word.last, out_o.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_status();
    test_delta_lengths();
    test_running_status();
    test_meta_events();
    test_random_traffic(150);
    test_drain_pause();
    test_back_to_back();
    test_random_traffic(150);
    no_idle = 1'b1;
    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mte_pkg.sv
rtl/core/mte_front.sv
rtl/core/mte_queue.sv
rtl/core/mte_back.sv
rtl/core/midi_track_event_encoder_unit.sv
verif/midi_track_event_encoder_unit_tb.sv
